@@ hw/rtl/cstr_pkg.sv @@
package cstr_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_NL    = 8'h0a;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       out_last;
  } cstr_res_t;

  // results produced by one accepted word, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    cstr_res_t  r0;
    cstr_res_t  r1;
  } cstr_push_t;

endpackage

@@ hw/rtl/cstr_in_if.sv @@
interface cstr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

@@ hw/rtl/cstr_out_if.sv @@
interface cstr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       out_last;

  modport source (output valid, output out_byte, output out_valid, output out_last,
                  input ready);
  modport sink   (input valid, input out_byte, input out_valid, input out_last,
                  output ready);
endinterface

@@ hw/rtl/cstr_scan.sv @@
module cstr_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                last_byte,
  output cstr_pkg::cstr_push_t push
);
  import cstr_pkg::*;

  typedef enum logic [2:0] {
    M_NORMAL = 3'd0,
    M_SLASH  = 3'd1,
    M_LINE   = 3'd2,
    M_BLOCK  = 3'd3,
    M_STAR   = 3'd4
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [1:0] n;
  logic [7:0] b0, b1;

  always_comb begin
    n        = 2'd0;
    b0       = in_byte;
    b1       = in_byte;
    mode_nxt = M_NORMAL;
    case (mode_r)
      M_SLASH: begin
        if (in_byte == CH_SLASH) begin
          mode_nxt = M_LINE;
        end else if (in_byte == CH_STAR) begin
          mode_nxt = M_BLOCK;
        end else begin
          n  = 2'd2;
          b0 = CH_SLASH;
        end
      end
      M_LINE: begin
        if (in_byte == CH_NL) begin
          n = 2'd1;
        end else begin
          mode_nxt = M_LINE;
        end
      end
      M_BLOCK, M_STAR: begin
        if (mode_r == M_STAR && in_byte == CH_SLASH) begin
          mode_nxt = M_NORMAL;
        end else if (last_byte) begin
          n = 2'd1;
        end else if (in_byte == CH_STAR) begin
          mode_nxt = M_STAR;
        end else begin
          if (in_byte == CH_NL) n = 2'd1;
          mode_nxt = M_BLOCK;
        end
      end
      default: begin
        if (in_byte == CH_SLASH && !last_byte) begin
          mode_nxt = M_SLASH;
        end else begin
          n = 2'd1;
        end
      end
    endcase
    if (last_byte) mode_nxt = M_NORMAL;

    push.r0.out_byte  = b0;
    push.r0.out_valid = 1'b1;
    push.r0.out_last  = last_byte && (n == 2'd1);
    push.r1.out_byte  = b1;
    push.r1.out_valid = 1'b1;
    push.r1.out_last  = last_byte;
    push.cnt          = n;
    if (last_byte && n == 2'd0) begin
      // bare end marker
      push.r0.out_byte  = 8'd0;
      push.r0.out_valid = 1'b0;
      push.r0.out_last  = 1'b1;
      push.cnt          = 2'd1;
    end
    if (!accept) push.cnt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
    end else if (accept) begin
      mode_r <= mode_nxt;
    end
  end

endmodule

@@ hw/rtl/cstr_outq.sv @@
module cstr_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cstr_pkg::cstr_push_t push,
  input  logic                 pop,
  output logic                 room,
  output logic                 avail,
  output cstr_pkg::cstr_res_t  head
);
  import cstr_pkg::*;

  localparam int Depth = 3;

  cstr_res_t  q_r [Depth];
  cstr_res_t  q_nxt [Depth];
  logic [1:0] cnt_r, cnt_nxt, base;

  assign room  = (cnt_r <= 2'd1);
  assign avail = (cnt_r != 2'd0);
  assign head  = q_r[0];

  always_comb begin
    for (int i = 0; i < Depth - 1; i++) begin
      q_nxt[i] = pop ? q_r[i + 1] : q_r[i];
    end
    q_nxt[Depth - 1] = q_r[Depth - 1];
    base = cnt_r - {1'b0, pop};
    if (push.cnt != 2'd0) q_nxt[base] = push.r0;
    if (push.cnt == 2'd2) q_nxt[base + 2'd1] = push.r1;
    cnt_nxt = base + push.cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

@@ hw/rtl/comment_stripper.sv @@
// Strips C-style line and block comments from a byte stream, keeping newlines;
// string literals are not recognized. One word is taken per cycle while the
// queue has room, and its results land in a three-entry output queue in the
// next cycle. A word that releases a held slash yields two results, so the
// output side has one more result to drain; input stalls only when the queue
// holds two or more. The final word always closes with out_last set, as a bare
// end marker (out_valid low, out_byte zero) when it leaves no character.
module comment_stripper (
  input  logic       clk,
  input  logic       rst_n,
  cstr_in_if.sink    in_ch,
  cstr_out_if.source out_ch
);
  import cstr_pkg::*;

  cstr_push_t push;
  cstr_res_t  head;
  logic       room, avail, accept, pop;

  assign accept = in_ch.valid && room;
  assign pop    = avail && out_ch.ready;

  assign in_ch.ready      = room;
  assign out_ch.valid     = avail;
  assign out_ch.out_byte  = head.out_byte;
  assign out_ch.out_valid = head.out_valid;
  assign out_ch.out_last  = head.out_last;

  cstr_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_byte   (in_ch.in_byte),
    .last_byte (in_ch.last_byte),
    .push      (push)
  );

  cstr_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .room  (room),
    .avail (avail),
    .head  (head)
  );

endmodule
